// ===== rtl/core/bc3_block_decoder_assert.svh =====
// assertion macros for the bc3 block decoder
// expects clk_i and rst_ni in the scope of each use
`ifndef BC3_BLOCK_DECODER_ASSERT_SVH
`define BC3_BLOCK_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define BC3_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bc3 same-cycle check failed");
// antecedent implies consequent in the next cycle
`define BC3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bc3 next-cycle check failed");
`else
`define BC3_ASSERT_IMPLY(lbl, ante, cons)
`define BC3_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/bc3_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and helpers for the bc3 block decoder
// no dependencies
package bc3_pkg;

  // channel byte order codes of the pixel_format register
  typedef enum logic [1:0] {
    FMT_BGRA = 2'd0,
    FMT_RGBA = 2'd1,
    FMT_ARGB = 2'd2,
    FMT_ABGR = 2'd3
  } pix_fmt_e;

  // how an alpha numerator turns into the final alpha value
  typedef enum logic [1:0] {
    ADIV_NONE = 2'd0,
    ADIV_7    = 2'd1,
    ADIV_5    = 2'd2
  } adiv_e;

  // register index of pixel_format
  localparam logic REG_PIXEL_FORMAT = 1'b0;

  // reciprocal multipliers, exact for the numerator ranges used here
  localparam logic [11:0] RECIP7  = 12'd2341;   // x/7 = (x*2341) >> 14, x < 2048
  localparam logic [10:0] RECIP5  = 11'd1639;   // x/5 = (x*1639) >> 13, x < 2048
  localparam logic [9:0]  RECIP3  = 10'd683;    // x/3 = (x*683) >> 11, x < 1024
  localparam logic [13:0] RECIP31 = 14'd8457;   // x/31 = (x*8457) >> 18, x < 8192
  localparam logic [14:0] RECIP63 = 15'd16645;  // x/63 = (x*16645) >> 20, x < 16384

  // one classified block as it sits in the queue
  typedef struct packed {
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic        alpha8;   // alpha0 > alpha1: eight-value mode
    logic [47:0] a_idx;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic [31:0] c_idx;
  } blk_t;

  // 5-bit to 8-bit expansion with rounding: (c*255 + 15) / 31
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] num;
    logic [26:0] prod;
    num  = {c, 8'b0} - {8'b0, c} + 13'd15;
    prod = 27'(num) * 27'(RECIP31);
    return prod[25:18];
  endfunction

  // 6-bit to 8-bit expansion with rounding: (c*255 + 31) / 63
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] num;
    logic [28:0] prod;
    num  = {c, 8'b0} - {8'b0, c} + 14'd31;
    prod = 29'(num) * 29'(RECIP63);
    return prod[27:20];
  endfunction

endpackage

// ===== rtl/core/bc3_queue.sv =====
`timescale 1ns / 1ps
// short block queue between the front and the back end
// depends on bc3_pkg (blk_t) and bc3_block_decoder_assert.svh
`include "bc3_block_decoder_assert.svh"
module bc3_queue #(
  parameter int DEPTH = 2  // 2 or more
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  bc3_pkg::blk_t wdata_i,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output bc3_pkg::blk_t rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bc3_pkg::blk_t   mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  // status and head entry
  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign rdata_o      = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `BC3_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_q <= CW'(DEPTH))
  `BC3_ASSERT_NEXT(a_pop_moves_head, do_pop, rd_ptr_q != $past(rd_ptr_q))

endmodule

// ===== rtl/core/bc3_front.sv =====
`timescale 1ns / 1ps
// front end: takes a block transaction, expands endpoints, picks alpha mode
// depends on bc3_pkg
module bc3_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          blk_valid_i,
  output logic          blk_ready_o,
  input  logic [63:0]   alpha_half_i,
  input  logic [63:0]   color_half_i,
  output logic          push_o,
  input  logic          push_ready_i,
  output bc3_pkg::blk_t entry_o
);

  logic          vld_q, vld_d;
  bc3_pkg::blk_t ent_q, ent_d;
  logic          accept;

  assign blk_ready_o = !vld_q || push_ready_i;
  assign accept      = blk_valid_i & blk_ready_o;
  assign push_o      = vld_q;
  assign entry_o     = ent_q;

  // classify the incoming block
  always_comb begin
    ent_d.a0     = alpha_half_i[7:0];
    ent_d.a1     = alpha_half_i[15:8];
    ent_d.alpha8 = (alpha_half_i[7:0] > alpha_half_i[15:8]);
    ent_d.a_idx  = alpha_half_i[63:16];
    ent_d.r0     = bc3_pkg::expand5(color_half_i[15:11]);
    ent_d.g0     = bc3_pkg::expand6(color_half_i[10:5]);
    ent_d.b0     = bc3_pkg::expand5(color_half_i[4:0]);
    ent_d.r1     = bc3_pkg::expand5(color_half_i[31:27]);
    ent_d.g1     = bc3_pkg::expand6(color_half_i[26:21]);
    ent_d.b1     = bc3_pkg::expand5(color_half_i[20:16]);
    ent_d.c_idx  = color_half_i[63:32];
  end

  // holding stage toward the queue
  assign vld_d = accept | (vld_q & ~push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= ent_d;
    end
  end

endmodule

// ===== rtl/core/bc3_back.sv =====
`timescale 1ns / 1ps
// back end: walks the 16 texels of a block, one per cycle unless the texel output stalls, in two stages
// depends on bc3_pkg and bc3_block_decoder_assert.svh
`include "bc3_block_decoder_assert.svh"
module bc3_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  bc3_pkg::blk_t q_data_i,
  output logic          pop_o,
  input  logic [1:0]    pixel_format_i,
  output logic          texel_valid_o,
  input  logic          texel_ready_i,
  output logic [31:0]   texel_color_o,
  output logic [3:0]    texel_position_o,
  output logic          last_texel_o
);

  // current block and texel counter
  logic          cur_valid_q, cur_valid_d;
  bc3_pkg::blk_t cur_q;
  logic [3:0]    cnt_q, cnt_d;

  // stage 1: numerators
  logic           s1_valid_q, s1_valid_d;
  logic [10:0]    s1_a_num_q, a_num;
  bc3_pkg::adiv_e s1_a_div_q, a_div;
  logic [9:0]     s1_r_num_q, s1_g_num_q, s1_b_num_q;
  logic           s1_c_div_q;
  logic [3:0]     s1_pos_q;

  // stage 2: output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] color_q, color_d;
  logic [3:0]  pos_q;
  logic        last_q;

  logic       out_adv, s1_adv, issue, done;
  logic [5:0] a_bit;
  logic [4:0] c_bit;
  logic [2:0] acode, w0, w1;
  logic [1:0] ccode;

  logic [22:0] p7;
  logic [21:0] p5;
  logic [19:0] pr, pg, pb;
  logic [7:0]  a_val, r_val, g_val, b_val;

  // color numerator for one channel: direct endpoint or weighted sum of thirds
  function automatic logic [9:0] cnum(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [1:0] code);
    logic [9:0] res;
    case (code)
      2'd0:    res = {2'b00, c0};
      2'd1:    res = {2'b00, c1};
      2'd2:    res = {1'b0, c0, 1'b0} + {2'b00, c1};
      default: res = {2'b00, c0} + {1'b0, c1, 1'b0};
    endcase
    return res;
  endfunction

  // pipeline flow
  assign out_adv = !out_valid_q || texel_ready_i;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign issue   = cur_valid_q && s1_adv;
  assign done    = issue && (cnt_q == 4'd15);
  assign pop_o   = q_valid_i && (!cur_valid_q || done);

  always_comb begin
    cur_valid_d = cur_valid_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
    end else if (done) begin
      cur_valid_d = 1'b0;
    end
    cnt_d      = issue ? cnt_q + 1'b1 : cnt_q;
    s1_valid_d = s1_adv ? issue : s1_valid_q;
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  // index fields of the current texel
  assign a_bit = {1'b0, cnt_q, 1'b0} + {2'b00, cnt_q};
  assign c_bit = {cnt_q, 1'b0};
  assign acode = cur_q.a_idx[a_bit +: 3];
  assign ccode = cur_q.c_idx[c_bit +: 2];

  // alpha numerator and divide selection
  always_comb begin
    w0    = '0;
    w1    = acode - 3'd1;
    a_num = '0;
    a_div = bc3_pkg::ADIV_NONE;
    if (acode == 3'd0) begin
      a_num = {3'b000, cur_q.a0};
    end else if (acode == 3'd1) begin
      a_num = {3'b000, cur_q.a1};
    end else if (cur_q.alpha8) begin
      w0    = 3'(4'd8 - {1'b0, acode});
      a_num = {8'b0, w0} * {3'b000, cur_q.a0} + {8'b0, w1} * {3'b000, cur_q.a1};
      a_div = bc3_pkg::ADIV_7;
    end else if (acode == 3'd6) begin
      a_num = '0;
    end else if (acode == 3'd7) begin
      a_num = 11'd255;
    end else begin
      w0    = 3'd6 - acode;
      a_num = {8'b0, w0} * {3'b000, cur_q.a0} + {8'b0, w1} * {3'b000, cur_q.a1};
      a_div = bc3_pkg::ADIV_5;
    end
  end

  // division by constants and channel packing
  assign p7 = 23'(s1_a_num_q) * 23'(bc3_pkg::RECIP7);
  assign p5 = 22'(s1_a_num_q) * 22'(bc3_pkg::RECIP5);
  assign pr = 20'(s1_r_num_q) * 20'(bc3_pkg::RECIP3);
  assign pg = 20'(s1_g_num_q) * 20'(bc3_pkg::RECIP3);
  assign pb = 20'(s1_b_num_q) * 20'(bc3_pkg::RECIP3);

  always_comb begin
    case (s1_a_div_q)
      bc3_pkg::ADIV_7: a_val = p7[21:14];
      bc3_pkg::ADIV_5: a_val = p5[20:13];
      default:         a_val = s1_a_num_q[7:0];
    endcase
    r_val = s1_c_div_q ? pr[18:11] : s1_r_num_q[7:0];
    g_val = s1_c_div_q ? pg[18:11] : s1_g_num_q[7:0];
    b_val = s1_c_div_q ? pb[18:11] : s1_b_num_q[7:0];
    case (bc3_pkg::pix_fmt_e'(pixel_format_i))
      bc3_pkg::FMT_RGBA: color_d = {a_val, b_val, g_val, r_val};
      bc3_pkg::FMT_ARGB: color_d = {b_val, g_val, r_val, a_val};
      bc3_pkg::FMT_ABGR: color_d = {r_val, g_val, b_val, a_val};
      default:           color_d = {a_val, r_val, g_val, b_val};
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cnt_q       <= cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (issue) begin
      s1_a_num_q <= a_num;
      s1_a_div_q <= a_div;
      s1_r_num_q <= cnum(cur_q.r0, cur_q.r1, ccode);
      s1_g_num_q <= cnum(cur_q.g0, cur_q.g1, ccode);
      s1_b_num_q <= cnum(cur_q.b0, cur_q.b1, ccode);
      s1_c_div_q <= ccode[1];
      s1_pos_q   <= cnt_q;
    end
    if (out_adv && s1_valid_q) begin
      color_q <= color_d;
      pos_q   <= s1_pos_q;
      last_q  <= (s1_pos_q == 4'd15);
    end
  end

  assign texel_valid_o    = out_valid_q;
  assign texel_color_o    = color_q;
  assign texel_position_o = pos_q;
  assign last_texel_o     = last_q;

  `BC3_ASSERT_IMPLY(a_last_pos, out_valid_q && last_q, pos_q == 4'd15)
  `BC3_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_adv, s1_valid_q && $stable(s1_pos_q))
  `BC3_ASSERT_NEXT(a_done_wraps, done, cnt_q == 4'd0)

endmodule

// ===== rtl/core/bc3_block_decoder.sv =====
`timescale 1ns / 1ps
// bc3 block decoder top level: front end, block queue, texel back end, apb register
// depends on bc3_pkg, bc3_front, bc3_queue, bc3_back
//
//  channel   direction  handshake                  payload
//  block     in         block_valid_i/ready_o      alpha_half_i, color_half_i
//  texel     out        texel_valid_o/ready_i      texel_color_o, texel_position_o,
//                                                  last_texel_o
//  config    in         apb psel/penable/pready    paddr, pwdata, prdata
//
// one block yields 16 texel transactions, one per cycle unless the texel output stalls;
// the back end texel path sets the block rate
// a block goes via the front register, queue and current block register to the stages
// the front end takes a new block while up to QUEUE_DEPTH + 2 earlier blocks are
// queued or in decode; a texel stall backs up through the back end and queue and
// reaches block_ready_o only once those are full
// reset clears all valid state and sets pixel_format to BGRA
module bc3_block_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        block_valid_i,
  output logic        block_ready_o,
  input  logic [63:0] alpha_half_i,
  input  logic [63:0] color_half_i,
  output logic        texel_valid_o,
  input  logic        texel_ready_i,
  output logic [31:0] texel_color_o,
  output logic [3:0]  texel_position_o,
  output logic        last_texel_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          fq_push, fq_ready;
  bc3_pkg::blk_t fq_data;
  logic          qb_valid, qb_pop;
  bc3_pkg::blk_t qb_data;
  logic [1:0]    pix_fmt_q, pix_fmt_d;
  logic          reg_wr;

  // apb register
  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite & (paddr[2] == bc3_pkg::REG_PIXEL_FORMAT);
  assign pix_fmt_d = reg_wr ? pwdata[1:0] : pix_fmt_q;
  assign prdata = (paddr[2] == bc3_pkg::REG_PIXEL_FORMAT) ? {30'b0, pix_fmt_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_fmt_q <= bc3_pkg::FMT_BGRA;
    end else begin
      pix_fmt_q <= pix_fmt_d;
    end
  end

  // block intake
  bc3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blk_valid_i  (block_valid_i),
    .blk_ready_o  (block_ready_o),
    .alpha_half_i (alpha_half_i),
    .color_half_i (color_half_i),
    .push_o       (fq_push),
    .push_ready_i (fq_ready),
    .entry_o      (fq_data)
  );

  // decoupling queue
  bc3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fq_push),
    .push_ready_o (fq_ready),
    .wdata_i      (fq_data),
    .pop_i        (qb_pop),
    .pop_valid_o  (qb_valid),
    .rdata_o      (qb_data)
  );

  // texel generation
  bc3_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (qb_valid),
    .q_data_i         (qb_data),
    .pop_o            (qb_pop),
    .pixel_format_i   (pix_fmt_q),
    .texel_valid_o    (texel_valid_o),
    .texel_ready_i    (texel_ready_i),
    .texel_color_o    (texel_color_o),
    .texel_position_o (texel_position_o),
    .last_texel_o     (last_texel_o)
  );

endmodule

// ===== tb/sv/bc3_block_decoder_tb.sv =====
`timescale 1ns / 1ps
// testbench for bc3_block_decoder: checks every decoded texel against a local decoder
// model or a typed-in colour, under each channel byte order set through the apb register
// depends on bc3_pkg and the bc3_block_decoder rtl
module bc3_block_decoder_tb;

  localparam int          LIMIT_CYCLES     = 400000;
  localparam int          RAND_PER_PHASE   = 100;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          DRAIN_CYCLES     = 24;
  localparam int          N_ROWS           = 13;
  localparam logic [2:0]  ADDR_PIXEL_FORMAT = {bc3_pkg::REG_PIXEL_FORMAT, 2'b00};
  localparam logic [2:0]  ADDR_SPARE        = 3'd4;  // register index 1, not implemented

  // one expected texel transaction
  typedef struct packed {
    logic [31:0] color;
    logic [3:0]  pos;
    logic        last;
  } texel_exp_t;

  // one row of the directed block table
  typedef struct packed {
    logic [63:0] ah;
    logic [63:0] ch;
    logic        known;
    logic [31:0] texel;
  } blk_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        block_valid_i;
  logic        block_ready_o;
  logic [63:0] alpha_half_i;
  logic [63:0] color_half_i;
  logic        texel_valid_o;
  logic        texel_ready_i;
  logic [31:0] texel_color_o;
  logic [3:0]  texel_position_o;
  logic        last_texel_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  texel_exp_t         texel_exp_q[$];
  texel_exp_t         head;
  bc3_pkg::pix_fmt_e  fmt_q;
  blk_row_t           dir_rows [N_ROWS];
  int                 mismatches;
  int                 texels_seen;
  int                 blocks_sent;
  int                 cycles;
  int                 hold_left;
  bit                 hold_arm;
  bit                 src_quiet;
  bit                 rdy_quiet;

  bc3_block_decoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .block_valid_i    (block_valid_i),
    .block_ready_o    (block_ready_o),
    .alpha_half_i     (alpha_half_i),
    .color_half_i     (color_half_i),
    .texel_valid_o    (texel_valid_o),
    .texel_ready_i    (texel_ready_i),
    .texel_color_o    (texel_color_o),
    .texel_position_o (texel_position_o),
    .last_texel_o     (last_texel_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // endpoint widening to 8 bits with rounding
  function automatic int unsigned widen(input int unsigned c, input int unsigned maxv);
    return (c * 255 + maxv / 2) / maxv;
  endfunction

  // one colour channel for a 2-bit index, four-colour mode only
  function automatic int unsigned blend(input int unsigned c0, input int unsigned c1,
                                        input logic [1:0] code);
    case (code)
      2'd0: return c0;
      2'd1: return c1;
      2'd2: return (2 * c0 + c1) / 3;
      default: return (c0 + 2 * c1) / 3;
    endcase
  endfunction

  // packed colour of texel t of a block under byte order f
  function automatic logic [31:0] decode_texel(input logic [63:0] ah, input logic [63:0] ch,
                                               input int t, input bc3_pkg::pix_fmt_e f);
    int unsigned a0, a1, acode, alpha;
    int unsigned r0, g0, b0, r1, g1, b1;
    logic [1:0]  ccode;
    logic [7:0]  ab, rb, gb, bb;
    a0    = ah[7:0];
    a1    = ah[15:8];
    acode = ah[16 + 3 * t +: 3];
    ccode = ch[32 + 2 * t +: 2];
    r0 = widen(ch[15:11], 31);
    g0 = widen(ch[10:5], 63);
    b0 = widen(ch[4:0], 31);
    r1 = widen(ch[31:27], 31);
    g1 = widen(ch[26:21], 63);
    b1 = widen(ch[20:16], 31);
    // alpha: eight-value mode only when alpha0 is strictly above alpha1
    if (acode == 0) alpha = a0;
    else if (acode == 1) alpha = a1;
    else if (a0 > a1) alpha = ((8 - acode) * a0 + (acode - 1) * a1) / 7;
    else if (acode == 6) alpha = 0;
    else if (acode == 7) alpha = 255;
    else alpha = ((6 - acode) * a0 + (acode - 1) * a1) / 5;
    ab = alpha[7:0];
    rb = 8'(blend(r0, r1, ccode));
    gb = 8'(blend(g0, g1, ccode));
    bb = 8'(blend(b0, b1, ccode));
    case (f)
      bc3_pkg::FMT_RGBA: return {ab, bb, gb, rb};
      bc3_pkg::FMT_ARGB: return {bb, gb, rb, ab};
      bc3_pkg::FMT_ABGR: return {rb, gb, bb, ab};
      default:           return {ab, rb, gb, bb};
    endcase
  endfunction

  // offer one block, wait for its transaction, then queue its 16 texels
  task automatic offer_block(input logic [63:0] ah, input logic [63:0] ch,
                             input logic known, input logic [31:0] known_color);
    int gap;
    texel_exp_t e;
    gap = 0;
    if (!src_quiet && $urandom_range(0, 99) < 21) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk_i);
      block_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    block_valid_i <= 1'b1;
    alpha_half_i  <= ah;
    color_half_i  <= ch;
    do @(posedge clk_i); while (!block_ready_o);
    blocks_sent++;
    for (int t = 0; t < 16; t++) begin
      e.color = known ? known_color : decode_texel(ah, ch, t, fmt_q);
      e.pos   = 4'(t);
      e.last  = (t == 15);
      texel_exp_q.push_back(e);
    end
  endtask

  // random block, biased toward the mode boundaries
  task automatic rand_block(output logic [63:0] ah, output logic [63:0] ch);
    ah = {$urandom, $urandom};
    ch = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ah[15:8] = ah[7:0];
      1: ch[31:16] = ch[15:0];
      2: ah[15:0] = {$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00};
      3: ch[31:0] = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                     $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
      4: ah[15:8] = ah[7:0] + 8'd1;
      default: ;
    endcase
  endtask

  // apb write, setup phase then access phase
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_PIXEL_FORMAT) fmt_q = bc3_pkg::pix_fmt_e'(data[1:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // apb read of pixel_format, checked against the local copy
  task automatic apb_check_format();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_PIXEL_FORMAT;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[1:0] !== fmt_q) begin
      mismatches++;
      $display("%0t: pixel_format read expected %0d got %0d", $time, fmt_q, prdata[1:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every queued texel has come out
  task automatic drain();
    while (texel_exp_q.size() != 0) @(posedge clk_i);
  endtask

  // texel receiver: random stalls, a quiet window and one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        texel_ready_i <= 1'b0;
      end else begin
        texel_ready_i <= rdy_quiet || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // texel checker, oldest expectation first
  always @(posedge clk_i) begin
    if (rst_ni && texel_valid_o && texel_ready_i) begin
      texels_seen++;
      if (texel_exp_q.size() == 0) begin
        mismatches++;
        $display("%0t: texel expected none got color %h position %0d", $time,
                 texel_color_o, texel_position_o);
      end else begin
        head = texel_exp_q.pop_front();
        if (texel_color_o !== head.color) begin
          mismatches++;
          $display("%0t: texel color expected %h got %h", $time, head.color, texel_color_o);
        end
        if (texel_position_o !== head.pos) begin
          mismatches++;
          $display("%0t: texel position expected %0d got %0d", $time, head.pos,
                   texel_position_o);
        end
        if (last_texel_o !== head.last) begin
          mismatches++;
          $display("%0t: last texel expected %b got %b", $time, head.last, last_texel_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("bc3_block_decoder test failed");
      $finish;
    end
  end

  // directed table, expected colour typed in where it is plain (byte order BGRA)
  initial begin
    dir_rows[0]  = {64'h0, 64'h0, 1'b1, 32'h0000_0000};
    dir_rows[1]  = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF};
    dir_rows[2]  = {64'h0000_0000_0000_00FF, 64'h0000_0000_0000_F800, 1'b1, 32'hFFFF_0000};
    dir_rows[3]  = {64'h0, 64'h0000_0000_0000_07E0, 1'b1, 32'h0000_FF00};
    dir_rows[4]  = {64'h0000_0000_0000_0080, 64'h0000_0000_0000_001F, 1'b1, 32'h8000_00FF};
    dir_rows[5]  = {48'hFAC688_FAC688, 8'h00, 8'hFF,
                    32'hE4E4_E4E4, 16'h001F, 16'hF800, 1'b0, 32'h0};
    dir_rows[6]  = {48'hFAC688_FAC688, 8'hF0, 8'h10,
                    32'h1B1B_1B1B, 16'hFFFF, 16'h0000, 1'b0, 32'h0};
    dir_rows[7]  = {48'hFAC688_FAC688, 8'h55, 8'h55,
                    32'hE4E4_E4E4, 16'h7BEF, 16'h7BEF, 1'b0, 32'h0};
    dir_rows[8]  = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 32'h0};
    dir_rows[9]  = {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0};
    dir_rows[10] = {48'hFAC688_FAC688, 8'h00, 8'h01,
                    32'hE4E4_E4E4, 16'h0001, 16'hFFFE, 1'b0, 32'h0};
    dir_rows[11] = {48'hFAC688_FAC688, 8'hFF, 8'hFE,
                    32'h9C9C_9C9C, 16'h0820, 16'hF7DF, 1'b0, 32'h0};
    dir_rows[12] = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 32'hFF00_0000};
  end

  // main sequence
  initial begin
    logic [63:0] ah, ch;
    logic [2:0]  addr;
    logic [31:0] data;
    rst_ni        = 1'b0;
    block_valid_i = 1'b0;
    alpha_half_i  = '0;
    color_half_i  = '0;
    texel_ready_i = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fmt_q         = bc3_pkg::FMT_BGRA;
    mismatches    = 0;
    texels_seen   = 0;
    blocks_sent   = 0;
    cycles        = 0;
    hold_left     = 0;
    hold_arm      = 1'b0;
    src_quiet     = 1'b0;
    rdy_quiet     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of the register, then the directed blocks
    apb_check_format();
    for (int i = 0; i < N_ROWS; i++)
      offer_block(dir_rows[i].ah, dir_rows[i].ch, dir_rows[i].known, dir_rows[i].texel);
    @(negedge clk_i);
    block_valid_i <= 1'b0;
    drain();

    // random phases, one register setting each
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin addr = ADDR_PIXEL_FORMAT; data = 32'(bc3_pkg::FMT_RGBA); end
        1: begin addr = ADDR_PIXEL_FORMAT; data = 32'hFFFF_FFFE; end  // upper bits dropped
        2: begin addr = ADDR_PIXEL_FORMAT; data = 32'(bc3_pkg::FMT_ABGR); end
        3: begin addr = ADDR_SPARE;        data = 32'(bc3_pkg::FMT_RGBA); end  // must be ignored
        default: begin addr = ADDR_PIXEL_FORMAT; data = 32'(bc3_pkg::FMT_BGRA); end
      endcase
      apb_write(addr, data);
      apb_check_format();
      src_quiet = (p == 2);
      rdy_quiet = (p == 2);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (p == 0 && n == 40) hold_arm = 1'b1;
        if (p == 1 && n == 50) begin
          // sender pauses until the decoder has drained
          @(negedge clk_i);
          block_valid_i <= 1'b0;
          drain();
        end
        rand_block(ah, ch);
        offer_block(ah, ch, 1'b0, 32'h0);
      end
      @(negedge clk_i);
      block_valid_i <= 1'b0;
      drain();
    end
    src_quiet = 1'b0;
    rdy_quiet = 1'b0;

    // let any stray texel show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d blocks and %0d texels over all four byte orders,", blocks_sent,
             texels_seen);
    $display("with a long texel hold-off, a full drain pause and an ignored spare write");
    if (mismatches == 0 && texel_exp_q.size() == 0) begin
      $display("bc3_block_decoder test passed");
    end else begin
      $display("bc3_block_decoder test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bc3_pkg.sv
rtl/core/bc3_queue.sv
rtl/core/bc3_front.sv
rtl/core/bc3_back.sv
rtl/core/bc3_block_decoder.sv
tb/sv/bc3_block_decoder_tb.sv
